/* sv/rcms_pkg.sv */
// shared types, constants and the microcode rom for rod_cut_max_segments
// no dependencies; imported by every other source file
package rcms_pkg;

    localparam int LEN_W  = 10;
    localparam int PIECE_W = 10;
    localparam logic [LEN_W-1:0] COUNT_MAX = 10'd1023;

    // register map, index = paddr[3:2]
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_PIECE_A = 2'd0;
    localparam reg_idx_t REG_PIECE_B = 2'd1;
    localparam reg_idx_t REG_PIECE_C = 2'd2;

    typedef logic [2:0] step_t;
    localparam step_t S_IDLE = 3'd0;
    localparam step_t S_INIT = 3'd1;
    localparam step_t S_RA   = 3'd2;
    localparam step_t S_RB   = 3'd3;
    localparam step_t S_RC   = 3'd4;
    localparam step_t S_WR   = 3'd5;
    localparam step_t S_FIN  = 3'd6;

    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_NONE = 2'd0;
    localparam rd_sel_t RD_A    = 2'd1;
    localparam rd_sel_t RD_B    = 2'd2;
    localparam rd_sel_t RD_C    = 2'd3;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_IN_FIRE  = 3'd1;
    localparam cond_t C_TRIVIAL  = 3'd2;
    localparam cond_t C_NOT_LAST = 3'd3;
    localparam cond_t C_OUT_FREE = 3'd4;

    typedef struct packed {
        rd_sel_t rd_sel;     // which piece length forms the read address
        logic    rd_next;    // read relative to entry i+1
        logic    fold;       // fold last read into the accumulator
        logic    acc_clr;    // start a fresh entry
        logic    wr_entry;   // write entry i, advance i
        logic    init;       // write entry 0, i = 1
        logic    in_rdy;
        logic    out_load;
        cond_t   cond;
        logic    wait_here;  // condition false: hold instead of falling through
        step_t   target;
    } uword_t;

    typedef struct packed {
        logic trivial;   // rod is 0 or longer than the table
        logic not_last;  // i != rod length
        logic out_free;  // output register can take a result
    } dp_status_t;

    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '0;
        unique case (s)
            S_IDLE:
            begin
                w.in_rdy    = 1'b1;
                w.cond      = C_IN_FIRE;
                w.wait_here = 1'b1;
                w.target    = S_INIT;
            end
            S_INIT:
            begin
                w.init   = 1'b1;
                w.cond   = C_TRIVIAL;
                w.target = S_FIN;
            end
            S_RA:
            begin
                w.rd_sel  = RD_A;
                w.acc_clr = 1'b1;
            end
            S_RB:
            begin
                w.rd_sel = RD_B;
                w.fold   = 1'b1;
            end
            S_RC:
            begin
                w.rd_sel = RD_C;
                w.fold   = 1'b1;
            end
            S_WR:
            begin
                // finish entry i and already start entry i+1
                w.fold     = 1'b1;
                w.wr_entry = 1'b1;
                w.acc_clr  = 1'b1;
                w.rd_sel   = RD_A;
                w.rd_next  = 1'b1;
                w.cond     = C_NOT_LAST;
                w.target   = S_RB;
            end
            S_FIN:
            begin
                w.out_load  = 1'b1;
                w.cond      = C_OUT_FREE;
                w.wait_here = 1'b1;
                w.target    = S_IDLE;
            end
            default:
            begin
                w.cond   = C_NEVER;
                w.target = S_IDLE;
                w.wait_here = 1'b0;
            end
        endcase
        return w;
    endfunction

endpackage

/* sv/rod_cut_max_segments.sv */
// top level of rod_cut_max_segments: apb register block, sequencer and datapath
// depends on rcms_pkg, rcms_seq, rcms_dp
//
//  channel   signals                                      direction
//  -------   -------------------------------------------  ---------
//  in        in_valid, in_ready, rod_length               sink
//  out       out_valid, out_ready, max_pieces, reachable  source
//  cfg       psel, penable, pwrite, paddr, pwdata,        apb slave
//            prdata, pready
//
// a transaction with rod length n > 0 fills table entries 1..n before the result
// register is loaded; the table memory has one read port, three reads per entry
// rod length 0, or longer than the table, goes from init straight to the result step
// the result waits in an output register; the next transaction is taken
// while it waits, a stalled result only stalls the end of the following one
// reset clears control state; the table needs no clearing
module rod_cut_max_segments #(
    parameter int MAX_LEN = 1023
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rcms_pkg::LEN_W-1:0]    rod_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rcms_pkg::LEN_W-1:0]    max_pieces,
    output logic                          reachable,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rcms_pkg::*;

    logic [PIECE_W-1:0] piece_a_reg, piece_b_reg, piece_c_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;
    uword_t             uw;
    dp_status_t         status;
    logic               in_fire;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_a_reg <= PIECE_W'(1);
            piece_b_reg <= PIECE_W'(1);
            piece_c_reg <= PIECE_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PIECE_A: piece_a_reg <= pwdata[PIECE_W-1:0];
                REG_PIECE_B: piece_b_reg <= pwdata[PIECE_W-1:0];
                REG_PIECE_C: piece_c_reg <= pwdata[PIECE_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PIECE_A: prdata = 32'(piece_a_reg);
            REG_PIECE_B: prdata = 32'(piece_b_reg);
            REG_PIECE_C: prdata = 32'(piece_c_reg);
            default:     prdata = '0;
        endcase
    end

    assign in_ready = uw.in_rdy;
    assign in_fire  = in_valid && in_ready;

    rcms_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .uw       (uw)
    );

    rcms_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .uw         (uw),
        .in_fire    (in_fire),
        .rod_length (rod_length),
        .piece_a    (piece_a_reg),
        .piece_b    (piece_b_reg),
        .piece_c    (piece_c_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .max_pieces (max_pieces),
        .reachable  (reachable),
        .status     (status)
    );

endmodule

/* sv/rcms_seq.sv */
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on rcms_pkg
module rcms_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rcms_pkg::dp_status_t status,
    output rcms_pkg::uword_t    uw
);
    import rcms_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_met;

    assign uw = ucode(step_reg);

    always_comb
    begin
        unique case (uw.cond)
            C_IN_FIRE:  cond_met = in_valid;
            C_TRIVIAL:  cond_met = status.trivial;
            C_NOT_LAST: cond_met = status.not_last;
            C_OUT_FREE: cond_met = status.out_free;
            default:    cond_met = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (cond_met)
            step_next = uw.target;
        else if (uw.wait_here)
            step_next = step_reg;
        else
            step_next = step_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_IDLE;
        else
            step_reg <= step_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == S_IDLE && in_valid) |=> step_reg == S_INIT)
        else $error("accepted transaction did not start the program");

    a_fin_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(step_reg == S_FIN) |-> ($past(step_reg) == S_INIT || $past(step_reg) == S_WR))
        else $error("result step entered from an unexpected step");

endmodule

/* sv/rcms_dp.sv */
// datapath: count table memory, read address generation, best-count fold,
// entry counter and output register; depends on rcms_pkg
module rcms_dp #(
    parameter int MAX_LEN = 1023
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcms_pkg::uword_t              uw,
    input  logic                          in_fire,
    input  logic [rcms_pkg::LEN_W-1:0]    rod_length,
    input  logic [rcms_pkg::PIECE_W-1:0]  piece_a,
    input  logic [rcms_pkg::PIECE_W-1:0]  piece_b,
    input  logic [rcms_pkg::PIECE_W-1:0]  piece_c,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rcms_pkg::LEN_W-1:0]    max_pieces,
    output logic                          reachable,
    output rcms_pkg::dp_status_t          status
);
    import rcms_pkg::*;

    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int CW = IW;
    localparam int NW = (IW > LEN_W) ? IW : LEN_W;
    localparam int WW = NW + 1;

    logic [CW:0]        mem [0:MAX_LEN];

    logic [LEN_W-1:0]   n_reg;
    logic [IW-1:0]      i_reg, i_next;
    logic               acc_v_reg, acc_v_next;
    logic [CW-1:0]      acc_c_reg, acc_c_next;
    logic               res_v_reg, res_v_next;
    logic [CW-1:0]      res_c_reg, res_c_next;
    logic               rd_ok_reg;
    logic               byp_reg;
    logic [CW:0]        wdat_reg;
    logic [CW:0]        rdat_reg;
    logic               out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]   max_pieces_reg;
    logic               reachable_reg;

    logic               oor;
    logic [WW-1:0]      idx_w, pl_w, diff_w, cnt_w;
    logic [PIECE_W-1:0] pl;
    logic               rd_ok;
    logic [IW-1:0]      raddr, waddr;
    logic               we;
    logic [CW:0]        wdata, src;
    logic [CW-1:0]      cand_c;
    logic               take;
    logic               fold_v;
    logic [CW-1:0]      fold_c;
    logic               load;

    assign oor = WW'(n_reg) > WW'(MAX_LEN);

    assign status.trivial  = oor || (n_reg == '0);
    assign status.not_last = WW'(i_reg) != WW'(n_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    // read address: entry (i or i+1) minus the selected piece length
    always_comb
    begin
        unique case (uw.rd_sel)
            RD_A:    pl = piece_a;
            RD_B:    pl = piece_b;
            RD_C:    pl = piece_c;
            default: pl = '0;
        endcase
    end

    assign idx_w  = WW'(i_reg) + (uw.rd_next ? WW'(1) : WW'(0));
    assign pl_w   = WW'(pl);
    assign diff_w = idx_w - pl_w;
    assign raddr  = diff_w[IW-1:0];
    assign rd_ok  = (uw.rd_sel != RD_NONE) && (pl != '0) && (pl_w <= idx_w);

    // entry written this cycle is forwarded to a read of the same address
    assign src    = byp_reg ? wdat_reg : rdat_reg;
    assign cand_c = src[CW-1:0] + CW'(1);
    assign take   = uw.fold && rd_ok_reg && src[CW] && (!acc_v_reg || cand_c > acc_c_reg);
    assign fold_v = take ? 1'b1 : acc_v_reg;
    assign fold_c = take ? cand_c : acc_c_reg;

    assign we    = (uw.init && !oor) || uw.wr_entry;
    assign waddr = uw.init ? '0 : i_reg;
    assign wdata = uw.init ? {1'b1, {CW{1'b0}}} : {fold_v, fold_c};

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdat_reg <= mem[raddr];
        byp_reg  <= we && (waddr == raddr);
        wdat_reg <= wdata;
    end

    always_comb
    begin
        acc_v_next = uw.acc_clr ? 1'b0 : fold_v;
        acc_c_next = uw.acc_clr ? '0 : fold_c;
        i_next     = i_reg;
        res_v_next = res_v_reg;
        res_c_next = res_c_reg;
        priority if (uw.init)
        begin
            i_next     = IW'(1);
            res_v_next = !oor;
            res_c_next = '0;
        end
        else if (uw.wr_entry)
        begin
            i_next     = i_reg + IW'(1);
            res_v_next = fold_v;
            res_c_next = fold_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= '0;
            acc_v_reg <= 1'b0;
            res_v_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            i_reg     <= i_next;
            acc_v_reg <= acc_v_next;
            res_v_reg <= res_v_next;
            rd_ok_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_c_reg <= acc_c_next;
        res_c_reg <= res_c_next;
        if (in_fire)
            n_reg <= rod_length;
    end

    // output register, counts above the port range saturate
    assign load  = uw.out_load && status.out_free;
    assign cnt_w = WW'(res_c_reg);

    always_comb
    begin
        priority if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reachable_reg <= res_v_reg;
            if (!res_v_reg)
                max_pieces_reg <= '0;
            else if (cnt_w > WW'(COUNT_MAX))
                max_pieces_reg <= COUNT_MAX;
            else
                max_pieces_reg <= cnt_w[LEN_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign max_pieces = max_pieces_reg;
    assign reachable  = reachable_reg;

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        uw.wr_entry |-> (WW'(i_reg) <= WW'(n_reg) && i_reg != '0))
        else $error("table entry written beyond requested length");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !reachable_reg) |-> max_pieces_reg == '0)
        else $error("unreachable result with nonzero count");

endmodule

/* tb/rcms_checker.sv */
// result checker for rod_cut_max_segments: tracks the piece-length registers,
// predicts each cut result and compares it with the block's output transactions
// depends on rcms_pkg
`timescale 1ns / 1ps

module rcms_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [rcms_pkg::LEN_W-1:0] rod_length,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [rcms_pkg::LEN_W-1:0] max_pieces,
    input  logic                       reachable,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pready,
    output int                         fails,
    output int                         pending
);
    import rcms_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0] pieces;
        logic             ok;
    } cut_result_t;

    logic [PIECE_W-1:0] piece_a;
    logic [PIECE_W-1:0] piece_b;
    logic [PIECE_W-1:0] piece_c;
    cut_result_t        cut_q[$];

    // bottom-up table of best piece counts for lengths 0..n
    function automatic cut_result_t best_cut(input logic [LEN_W-1:0] n,
                                             input logic [PIECE_W-1:0] a,
                                             input logic [PIECE_W-1:0] b,
                                             input logic [PIECE_W-1:0] c);
        int          best[0:1023];
        bit          hit[0:1023];
        int          lens[3];
        int          cand;
        cut_result_t res;
        lens[0] = a;
        lens[1] = b;
        lens[2] = c;
        best[0] = 0;
        hit[0] = 1'b1;
        for (int i = 1; i <= n; i++)
        begin
            best[i] = 0;
            hit[i] = 1'b0;
            for (int p = 0; p < 3; p++)
            begin
                // a zero length means the piece does not exist
                if (lens[p] != 0 && lens[p] <= i && hit[i - lens[p]])
                begin
                    cand = best[i - lens[p]] + 1;
                    if (!hit[i] || cand > best[i])
                    begin
                        best[i] = cand;
                        hit[i] = 1'b1;
                    end
                end
            end
        end
        res.ok = hit[n];
        if (!hit[n])
            res.pieces = '0;
        else if (best[n] > COUNT_MAX)
            res.pieces = COUNT_MAX;
        else
            res.pieces = best[n][LEN_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cut_result_t exp_cut;
        if (!rst_n)
        begin
            piece_a = 10'd1;
            piece_b = 10'd1;
            piece_c = 10'd1;
            cut_q.delete();
            pending = 0;
            fails = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_PIECE_A: piece_a = pwdata[PIECE_W-1:0];
                    REG_PIECE_B: piece_b = pwdata[PIECE_W-1:0];
                    REG_PIECE_C: piece_c = pwdata[PIECE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (cut_q.size() == 0)
                    report_mismatch($sformatf("unexpected result max_pieces=%0d reachable=%0b",
                                              max_pieces, reachable));
                else
                begin
                    exp_cut = cut_q.pop_front();
                    if (max_pieces !== exp_cut.pieces)
                        report_mismatch($sformatf("max_pieces %0d, predicted %0d",
                                                  max_pieces, exp_cut.pieces));
                    if (reachable !== exp_cut.ok)
                        report_mismatch($sformatf("reachable %0b, predicted %0b",
                                                  reachable, exp_cut.ok));
                end
            end
            if (in_valid && in_ready)
                cut_q.push_back(best_cut(rod_length, piece_a, piece_b, piece_c));
            pending = cut_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// testbench top for rod_cut_max_segments: clock, reset, rod length stimulus,
// piece-length register writes and the verdict
// depends on rcms_pkg, rod_cut_max_segments and rcms_checker
`timescale 1ns / 1ps

module tb_top;
    import rcms_pkg::*;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [LEN_W-1:0] rod_length = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [LEN_W-1:0] max_pieces;
    logic             reachable;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [3:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    int mismatches;
    int awaiting;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    rod_cut_max_segments dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rod_length (rod_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .max_pieces (max_pieces),
        .reachable  (reachable),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    rcms_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rod_length (rod_length),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .max_pieces (max_pieces),
        .reachable  (reachable),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fails      (mismatches),
        .pending    (awaiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    task automatic send_rod(input logic [LEN_W-1:0] n);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rod_length <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // hold off new transactions until every result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [PIECE_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(32-PIECE_W){1'b0}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pieces(input logic [PIECE_W-1:0] a, input logic [PIECE_W-1:0] b,
                              input logic [PIECE_W-1:0] c);
        apb_write(REG_PIECE_A, a);
        apb_write(REG_PIECE_B, b);
        apb_write(REG_PIECE_C, c);
    endtask

    // mostly short pieces so the table fills densely, now and then long or absent
    function automatic logic [PIECE_W-1:0] rand_piece();
        int r;
        r = $urandom_range(19);
        if (r < 14)
            return PIECE_W'($urandom_range(1, 12));
        else if (r < 19)
            return PIECE_W'($urandom_range(1, 1023));
        else
            return '0;
    endfunction

    initial
    begin
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset lengths of one: count equals rod length, up to the full table
        send_rod(10'd0);
        send_rod(10'd1);
        send_rod(10'd1023);
        wait_idle();

        // pieces longer than the rod and unreachable lengths
        set_pieces(10'd3, 10'd5, 10'd7);
        send_rod(10'd1);
        send_rod(10'd2);
        send_rod(10'd3);
        send_rod(10'd4);
        send_rod(10'd5);
        send_rod(10'd7);
        send_rod(10'd8);
        send_rod(10'd10);
        wait_idle();

        set_pieces(10'd1023, 10'd1023, 10'd1023);
        send_rod(10'd1022);
        send_rod(10'd1023);
        send_rod(10'd0);
        wait_idle();

        // a zero length register drops that piece
        set_pieces(10'd0, 10'd4, 10'd6);
        send_rod(10'd3);
        send_rod(10'd4);
        send_rod(10'd6);
        send_rod(10'd10);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int seg = 0; seg < 2; seg++)
            begin
                wait_idle();
                set_pieces(rand_piece(), rand_piece(), rand_piece());
                for (int k = 0; k < 21; k++)
                begin
                    if ($urandom_range(24) == 0)
                        wait_idle();
                    // long rods are slow, keep most of them short
                    r = $urandom_range(19);
                    if (r < 14)
                        send_rod(LEN_W'($urandom_range(0, 40)));
                    else if (r < 18)
                        send_rod(LEN_W'($urandom_range(0, 1023)));
                    else
                        send_rod(LEN_W'(1023 - $urandom_range(0, 3)));
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("rod_cut_max_segments test passed");
        else
            $display("rod_cut_max_segments test failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("rod_cut_max_segments test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/rcms_pkg.sv
sv/rcms_seq.sv
sv/rcms_dp.sv
sv/rod_cut_max_segments.sv
tb/rcms_checker.sv
tb/tb_top.sv
